### hw/rtl/hvn_pkg.sv
// Shared constants and types of the heightmap vertex and normal generator.
package hvn_pkg;

  localparam int MaxWidthDef  = 4096;
  localparam int MaxHeightDef = 4096;
  localparam int ResetSize    = 256;
  localparam int CfgDataW     = 13;
  localparam int ByteW        = 8;
  localparam int HeightW      = 24;
  localparam int CoordW       = 12;
  localparam int FracW        = 16;
  localparam int NormW        = 16;
  localparam int NormQW       = 17;
  localparam int NormDenW     = 26;
  localparam int SqW          = 52;

  typedef enum logic {
    CfgMapWidth  = 1'b0,
    CfgMapHeight = 1'b1
  } cfg_idx_e;

endpackage

### hw/rtl/hvn_in_if.sv
// Input channel of the heightmap vertex and normal generator.
interface hvn_in_if;
  logic                        valid;
  logic                        ready;
  logic                        flush;
  logic [hvn_pkg::ByteW-1:0]   red_byte;
  logic [hvn_pkg::ByteW-1:0]   green_byte;
  logic [hvn_pkg::ByteW-1:0]   blue_byte;

  modport source (output valid, flush, red_byte, green_byte, blue_byte, input ready);
  modport sink (input valid, flush, red_byte, green_byte, blue_byte, output ready);
endinterface

### hw/rtl/hvn_out_if.sv
// Output channel of the heightmap vertex and normal generator.
interface hvn_out_if;
  logic                              valid;
  logic                              ready;
  logic [hvn_pkg::CoordW-1:0]        vertex_col;
  logic [hvn_pkg::CoordW-1:0]        vertex_row;
  logic signed [hvn_pkg::FracW-1:0]  pos_x;
  logic signed [hvn_pkg::FracW-1:0]  pos_z;
  logic signed [hvn_pkg::HeightW-1:0] height_value;
  logic [hvn_pkg::FracW-1:0]         uv_u;
  logic signed [hvn_pkg::FracW:0]    uv_v;
  logic signed [hvn_pkg::NormW-1:0]  normal_x;
  logic [hvn_pkg::NormW-2:0]         normal_y;
  logic signed [hvn_pkg::NormW-1:0]  normal_z;
  logic                              frame_last;

  modport source (output valid, vertex_col, vertex_row, pos_x, pos_z, height_value, uv_u,
                  uv_v, normal_x, normal_y, normal_z, frame_last, input ready);
  modport sink (input valid, vertex_col, vertex_row, pos_x, pos_z, height_value, uv_u,
                uv_v, normal_x, normal_y, normal_z, frame_last, output ready);
endinterface

### hw/rtl/heightmap_vertex_normal_gen.sv
// Top level of the heightmap vertex and normal generator.
// Pixels enter on in_i in raster order, one beat each, with flush low. Each
// pixel of row r (r >= 1) produces on out_o the vertex of row r-1 at the same
// column, so output runs one row behind. After the last row, map_width flush
// beats release the final row; frame_last marks its last vertex. Beats that
// arrive out of turn (a flush before the last row, a pixel after it) are
// dropped. The two line stores are synchronous RAMs with one read and one
// write port; each beat taken in turn passes the read states S_RD0 and S_RD1
// and the write-back state S_RD2. A vertex then takes two squarings, a 26-step
// bit-serial square root and three 17-step dividers in parallel, and the next
// beat is taken only once the vertex has entered the output register. A beat
// of the first row returns to idle after write-back, and a dropped beat leaves
// the block idle. The UV dividers run beside the root.
// A finished vertex waits in an output register, so the next beat is taken
// while the receiver stalls; a second vertex waits until that register frees.
// Reset clears the counters and sets both sizes to 256, not the RAM contents.
// The user writes sizes through cfg_we_i while the block is idle; not enforced.
module heightmap_vertex_normal_gen #(
  parameter int MAX_WIDTH  = hvn_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = hvn_pkg::MaxHeightDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  hvn_pkg::cfg_idx_e            cfg_idx_i,
  input  logic [hvn_pkg::CfgDataW-1:0] cfg_data_i,
  hvn_in_if.sink                       in_i,
  hvn_out_if.source                    out_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);
  localparam int HW = hvn_pkg::HeightW;
  localparam int SqW = hvn_pkg::SqW;
  localparam int QW = hvn_pkg::NormQW;
  localparam int DW = hvn_pkg::NormDenW;
  localparam int FW = hvn_pkg::FracW;
  localparam int NumW = DW + QW - 1;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RD0  = 9'b000000010,
    S_RD1  = 9'b000000100,
    S_RD2  = 9'b000001000,
    S_MUL  = 9'b000010000,
    S_SUM  = 9'b000100000,
    S_SQRT = 9'b001000000,
    S_DIV  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_e;

  state_e state_q;

  logic [hvn_pkg::CfgDataW-1:0] cfg_w_q, cfg_h_q;
  logic [WW-1:0] w;
  logic [RW-1:0] h;

  always_comb begin
    logic [31:0] w32, h32;
    w32 = {{(32 - hvn_pkg::CfgDataW){1'b0}}, cfg_w_q};
    h32 = {{(32 - hvn_pkg::CfgDataW){1'b0}}, cfg_h_q};
    if (w32 < 32'd2) w32 = 32'd2;
    if (w32 > 32'(MAX_WIDTH)) w32 = 32'(MAX_WIDTH);
    if (h32 < 32'd2) h32 = 32'd2;
    if (h32 > 32'(MAX_HEIGHT)) h32 = 32'(MAX_HEIGHT);
    w = WW'(w32);
    h = RW'(h32);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= hvn_pkg::CfgDataW'(hvn_pkg::ResetSize);
      cfg_h_q <= hvn_pkg::CfgDataW'(hvn_pkg::ResetSize);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hvn_pkg::CfgMapWidth:  cfg_w_q <= cfg_data_i;
        hvn_pkg::CfgMapHeight: cfg_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic          flush_q;
  logic [HW-1:0] raw_q;
  logic [WW:0]   col_p1;
  logic          row_end, right_ok, awaiting, in_fire;

  assign col_p1   = (WW + 1)'(col_q) + 1'b1;
  assign row_end  = col_p1 >= {1'b0, w};
  assign right_ok = col_p1 < {1'b0, w};
  assign awaiting = row_q >= h;
  assign in_i.ready = state_q == S_IDLE;
  assign in_fire  = in_i.valid && in_i.ready;

  logic [HW-1:0] prev_mem [MAX_WIDTH];
  logic [HW-1:0] old_mem  [MAX_WIDTH];
  logic [HW-1:0] prev_rd_q, old_rd_q;
  logic [CW-1:0] prev_addr, old_addr;
  logic [HW-1:0] center_q, oldc_q;

  always_comb begin
    prev_addr = col_q;
    old_addr  = col_q;
    if (state_q == S_RD1) begin
      if (right_ok) prev_addr = CW'(col_p1);
      if (col_q != '0) old_addr = col_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_rd_q <= prev_mem[prev_addr];
    old_rd_q  <= old_mem[old_addr];
    if (state_q == S_RD2) begin
      old_mem[col_q] <= center_q;
      if (!flush_q) prev_mem[col_q] <= raw_q;
    end
  end

  logic [HW-1:0] left, right, above, below;
  logic [HW:0]   dx, dz;
  logic [HW-1:0] dxm_q, dzm_q;
  logic          dxs_q, dzs_q;
  logic [2*HW-1:0] dxsq_q, dzsq_q;
  logic [CW-1:0] vcol_q;
  logic [RW-1:0] vrow_q;
  logic          last_q;
  logic [HW-1:0] vheight_q;

  always_comb begin
    left  = (col_q != '0) ? old_rd_q : center_q;
    right = right_ok ? prev_rd_q : center_q;
    above = (row_q >= RW'(2)) ? oldc_q : center_q;
    below = flush_q ? center_q : raw_q;
    dx    = {1'b0, left} - {1'b0, right};
    dz    = {1'b0, above} - {1'b0, below};
  end

  logic [SqW-1:0] v_q, res_q, bitv, trial;
  logic [4:0]     k_q;
  logic [SqW-1:0] v_d, res_d;
  logic [DW-1:0]  len_q;
  logic           nd_start_q, uv_start;

  assign bitv  = SqW'(1) << {k_q, 1'b0};
  assign trial = res_q + bitv;
  always_comb begin
    if (v_q >= trial) begin
      v_d   = v_q - trial;
      res_d = (res_q >> 1) + bitv;
    end else begin
      v_d   = v_q;
      res_d = res_q >> 1;
    end
  end

  logic [NumW-1:0] nx, ny, nz;
  logic [QW-1:0]   qx, qy, qz;
  logic            dnx, dny, dnz;
  assign nx = (NumW'(dxm_q) << 15) + NumW'(len_q >> 1);
  assign ny = (NumW'(1) << (15 + 25)) + NumW'(len_q >> 1);
  assign nz = (NumW'(dzm_q) << 15) + NumW'(len_q >> 1);

  hvn_div #(.DEN_W(DW), .Q_W(QW)) u_div_x (
    .clk_i, .rst_ni, .start_i(nd_start_q), .rem_init_i(DW'(nx >> QW)),
    .num_lo_i(nx[QW-1:0]), .den_i(len_q), .quot_o(qx), .done_o(dnx));
  hvn_div #(.DEN_W(DW), .Q_W(QW)) u_div_y (
    .clk_i, .rst_ni, .start_i(nd_start_q), .rem_init_i(DW'(ny >> QW)),
    .num_lo_i(ny[QW-1:0]), .den_i(len_q), .quot_o(qy), .done_o(dny));
  hvn_div #(.DEN_W(DW), .Q_W(QW)) u_div_z (
    .clk_i, .rst_ni, .start_i(nd_start_q), .rem_init_i(DW'(nz >> QW)),
    .num_lo_i(nz[QW-1:0]), .den_i(len_q), .quot_o(qz), .done_o(dnz));

  logic          sat_u_q, sat_v_q;
  logic [FW-1:0] qu, qv;
  logic          dnu, dnv;
  assign uv_start = state_q == S_SUM;

  hvn_div #(.DEN_W(WW), .Q_W(FW)) u_div_u (
    .clk_i, .rst_ni, .start_i(uv_start),
    .rem_init_i(({1'b0, vcol_q} >= (CW + 1)'(w)) ? '0 : WW'(vcol_q)),
    .num_lo_i('0), .den_i(w), .quot_o(qu), .done_o(dnu));
  hvn_div #(.DEN_W(RW), .Q_W(FW)) u_div_v (
    .clk_i, .rst_ni, .start_i(uv_start), .rem_init_i((vrow_q >= h) ? '0 : vrow_q),
    .num_lo_i('0), .den_i(h), .quot_o(qv), .done_o(dnv));

  logic [FW-1:0] u_val, v_val;
  assign u_val = sat_u_q ? '1 : qu;
  assign v_val = sat_v_q ? '1 : qv;

  logic [31:0] vcol32, vrow32;
  assign vcol32 = 32'(vcol_q);
  assign vrow32 = 32'(vrow_q);

  logic [QW-1:0] nxs, nzs;
  assign nxs = dxs_q ? QW'(0) - qx : qx;
  assign nzs = dzs_q ? QW'(0) - qz : qz;

  logic out_load;
  assign out_load = (state_q == S_OUT) && (!out_o.valid || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      col_q      <= '0;
      row_q      <= '0;
      nd_start_q <= 1'b0;
      out_o.valid <= 1'b0;
    end else begin
      nd_start_q <= 1'b0;
      if (out_load) out_o.valid <= 1'b1;
      else if (out_o.ready) out_o.valid <= 1'b0;
      case (state_q)
        S_IDLE: if (in_fire && (in_i.flush == awaiting)) state_q <= S_RD0;
        S_RD0:  state_q <= S_RD1;
        S_RD1:  state_q <= S_RD2;
        S_RD2: begin
          if (row_end) begin
            col_q <= '0;
            row_q <= flush_q ? '0 : row_q + 1'b1;
          end else begin
            col_q <= CW'(col_p1);
          end
          state_q <= (row_q != '0) ? S_MUL : S_IDLE;
        end
        S_MUL:  state_q <= S_SUM;
        S_SUM:  state_q <= S_SQRT;
        S_SQRT: begin
          if (k_q == '0) begin
            state_q    <= S_DIV;
            nd_start_q <= 1'b1;
          end
        end
        S_DIV:  if (!nd_start_q && dnx && dny && dnz && dnu && dnv) state_q <= S_OUT;
        S_OUT:  if (out_load) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        flush_q <= in_i.flush;
        raw_q   <= {in_i.red_byte, in_i.green_byte, in_i.blue_byte};
      end
      S_RD1: begin
        center_q <= prev_rd_q;
        oldc_q   <= old_rd_q;
      end
      S_RD2: begin
        dxs_q     <= dx[HW];
        dzs_q     <= dz[HW];
        dxm_q     <= dx[HW] ? HW'(-dx) : dx[HW-1:0];
        dzm_q     <= dz[HW] ? HW'(-dz) : dz[HW-1:0];
        vcol_q    <= col_q;
        vrow_q    <= row_q - 1'b1;
        last_q    <= flush_q && row_end;
        vheight_q <= center_q ^ {1'b1, {(HW - 1){1'b0}}};
      end
      S_MUL: begin
        dxsq_q <= dxm_q * dxm_q;
        dzsq_q <= dzm_q * dzm_q;
      end
      S_SUM: begin
        v_q     <= SqW'(dxsq_q) + SqW'(dzsq_q) + (SqW'(1) << 50);
        res_q   <= '0;
        k_q     <= 5'd25;
        sat_u_q <= {1'b0, vcol_q} >= (CW + 1)'(w);
        sat_v_q <= vrow_q >= h;
      end
      S_SQRT: begin
        v_q   <= v_d;
        res_q <= res_d;
        k_q   <= k_q - 1'b1;
        len_q <= DW'(res_d);
      end
      default: ;
    endcase
    if (out_load) begin
      out_o.vertex_col   <= vcol32[hvn_pkg::CoordW-1:0];
      out_o.vertex_row   <= vrow32[hvn_pkg::CoordW-1:0];
      out_o.pos_x        <= {~u_val[FW-1], u_val[FW-2:0]};
      out_o.pos_z        <= {~v_val[FW-1], v_val[FW-2:0]};
      out_o.height_value <= vheight_q;
      out_o.uv_u         <= u_val;
      out_o.uv_v         <= (FW + 1)'(0) - {1'b0, v_val};
      out_o.normal_x     <= nxs[hvn_pkg::NormW-1:0];
      out_o.normal_y     <= (qy > QW'(32767)) ? 15'h7fff : qy[hvn_pkg::NormW-2:0];
      out_o.normal_z     <= nzs[hvn_pkg::NormW-1:0];
      out_o.frame_last   <= last_q;
    end
  end

endmodule

### hw/rtl/hvn_div.sv
// Restoring divider that produces one quotient bit per cycle.
module hvn_div #(
  parameter int DEN_W = 16,
  parameter int Q_W   = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DEN_W-1:0] rem_init_i,
  input  logic [Q_W-1:0]   num_lo_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [Q_W-1:0]   quot_o,
  output logic             done_o
);

  localparam int CntW = $clog2(Q_W + 1);

  logic             busy_q;
  logic [CntW-1:0]  cnt_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [Q_W-1:0]   lo_q;
  logic [Q_W-1:0]   quot_q;
  logic [DEN_W:0]   shifted;
  logic             ge;

  assign shifted = {rem_q, lo_q[Q_W-1]};
  assign ge      = shifted >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(Q_W);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 1'b1;
      busy_q <= cnt_q != CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_init_i;
      lo_q  <= num_lo_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q  <= ge ? DEN_W'(shifted - {1'b0, den_q}) : DEN_W'(shifted);
      lo_q   <= {lo_q[Q_W-2:0], 1'b0};
      quot_q <= {quot_q[Q_W-2:0], ge};
    end
  end

  assign quot_o = quot_q;
  assign done_o = !busy_q;

endmodule

### test/heightmap_vertex_normal_gen_tb.sv
// Testbench that checks the heightmap vertex and normal generator against its own vertex predictor.
`timescale 1ns / 1ps

module heightmap_vertex_normal_gen_tb;

  localparam int MaxSize   = 4096;
  localparam int DrainWait = 80;
  localparam int IdleLimit = 5000;

  typedef struct packed {
    logic [11:0] col;
    logic [11:0] row;
    logic [15:0] pos_x;
    logic [15:0] pos_z;
    logic [23:0] height;
    logic [15:0] uv_u;
    logic [16:0] uv_v;
    logic [15:0] nx;
    logic [14:0] ny;
    logic [15:0] nz;
    logic        last;
  } vertex_t;

  typedef struct packed {
    logic        flush;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic        known;
    logic [23:0] known_height;
    logic        known_last;
  } pixel_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  hvn_pkg::cfg_idx_e cfg_idx = hvn_pkg::CfgMapWidth;
  logic [hvn_pkg::CfgDataW-1:0] cfg_data = '0;

  hvn_in_if  in_if ();
  hvn_out_if out_if ();

  heightmap_vertex_normal_gen dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (in_if.sink),
    .out_o     (out_if.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [12:0] width_reg = 13'd256;
  logic [12:0] height_reg = 13'd256;
  int unsigned col_cnt = 0;
  int unsigned row_cnt = 0;
  logic [23:0] line_prev [MaxSize];
  logic [23:0] line_older [MaxSize];
  vertex_t vertex_q [$];

  int errors = 0;
  int beats_in = 0;
  int vertices_seen = 0;
  int maps_done = 0;
  int idle_cycles = 0;
  bit idle_en = 1'b1;
  bit in_hit;
  bit known_pending;
  pixel_row_t known_row;

  function automatic int unsigned clamp_size(logic [12:0] v);
    if (v < 2) return 2;
    if (v > MaxSize) return MaxSize;
    return 32'(v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unit_comp(longint d, longint unsigned len, longint lo, longint hi);
    longint unsigned mag = d < 0 ? -d : d;
    longint q = ((mag << 15) + len / 2) / len;
    if (d < 0) q = -q;
    if (q < lo) q = lo;
    if (q > hi) q = hi;
    return q;
  endfunction

  function automatic int unsigned frac16(int unsigned num, int unsigned den);
    longint unsigned q = (longint'(num) << 16) / den;
    return q > 65535 ? 32'd65535 : 32'(q);
  endfunction

  function automatic bit predict_vertex(input logic flush, input logic [23:0] raw,
                                        output vertex_t v);
    int unsigned w = clamp_size(width_reg);
    int unsigned h = clamp_size(height_reg);
    int unsigned col = col_cnt;
    int unsigned vrow, u, q;
    logic [23:0] center, left, right, above, below;
    longint dx, dz, dy;
    longint unsigned len;
    bit emit, row_end;
    v = '0;
    if (flush != (row_cnt >= h)) return 1'b0;
    if (col >= MaxSize) col = MaxSize - 1;
    center = line_prev[col];
    above = row_cnt >= 2 ? line_older[col] : center;
    left = col > 0 ? line_older[col-1] : center;
    right = col + 1 < w ? line_prev[col+1] : center;
    below = flush ? center : raw;
    emit = row_cnt >= 1;
    vrow = emit ? row_cnt - 1 : 0;
    row_end = col + 1 >= w;
    if (emit) begin
      dx = longint'(left) - longint'(right);
      dz = longint'(above) - longint'(below);
      dy = 64'd1 << 25;
      len = int_sqrt(dx * dx + dy * dy + dz * dz);
      u = frac16(col, w);
      q = frac16(vrow, h);
      v.col = col[11:0];
      v.row = vrow[11:0];
      v.pos_x = 16'(u + 32'h8000);
      v.pos_z = 16'(q + 32'h8000);
      v.height = center ^ 24'h800000;
      v.uv_u = u[15:0];
      v.uv_v = 17'(-q);
      v.nx = 16'(unit_comp(dx, len, -32768, 32767));
      v.ny = 15'(unit_comp(dy, len, 0, 32767));
      v.nz = 16'(unit_comp(dz, len, -32768, 32767));
      v.last = flush && row_end;
    end
    line_older[col] = line_prev[col];
    if (!flush) line_prev[col] = raw;
    if (row_end) begin
      col_cnt = 0;
      if (flush) begin
        row_cnt = 0;
        maps_done++;
      end else begin
        row_cnt++;
      end
    end else begin
      col_cnt = col + 1;
    end
    return emit;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
    errors++;
  endtask

  task automatic write_size(input hvn_pkg::cfg_idx_e idx, input logic [12:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == hvn_pkg::CfgMapWidth) width_reg = val;
    else height_reg = val;
  endtask

  task automatic send_beat(input logic flush, input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b);
    vertex_t v;
    while (idle_en && $urandom_range(99) < 25) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.flush <= flush;
    in_if.red_byte <= r;
    in_if.green_byte <= g;
    in_if.blue_byte <= b;
    @(negedge clk);
    while (!in_if.ready) @(negedge clk);
    if (predict_vertex(flush, {r, g, b}, v)) begin
      vertex_q.insert(vertex_q.size(), v);
      if (known_pending) begin
        if (v.height !== known_row.known_height)
          report_mismatch("table height", 32'(v.height), 32'(known_row.known_height));
        if (v.last !== known_row.known_last)
          report_mismatch("table frame_last", 32'(v.last), 32'(known_row.known_last));
      end
    end else if (known_pending) begin
      report_mismatch("table row gave no vertex", 0, 1);
    end
    known_pending = 1'b0;
    beats_in++;
    @(posedge clk);
  endtask

  task automatic drain_idle();
    in_if.valid <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic send_map(input int unsigned w, input int unsigned h, input int mode,
                          input bit noise);
    logic [7:0] r, g, b;
    for (int unsigned y = 0; y <= h; y++) begin
      for (int unsigned x = 0; x < w; x++) begin
        if (noise && $urandom_range(99) < 5) begin
          send_beat(y < h ? 1'b1 : 1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
        end
        case (mode)
          0: {r, g, b} = 24'($urandom);
          1: {r, g, b} = {8'h80, 8'($urandom_range(3)), 8'($urandom)};
          default: {r, g, b} = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
        endcase
        send_beat(y == h, r, g, b);
      end
    end
  endtask

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !idle_en || ($urandom_range(99) >= 25);
    end
  end

  always @(negedge clk) begin
    vertex_t got, want;
    in_hit = in_if.valid && in_if.ready;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = {out_if.vertex_col, out_if.vertex_row, out_if.pos_x, out_if.pos_z,
             out_if.height_value, out_if.uv_u, out_if.uv_v, out_if.normal_x,
             out_if.normal_y, out_if.normal_z, out_if.frame_last};
      vertices_seen++;
      if (vertex_q.size() == 0) begin
        report_mismatch("vertex with none expected", 32'(got.col), 0);
      end else begin
        want = vertex_q.pop_front();
        if (got.col !== want.col)
          report_mismatch("vertex_col", 32'(got.col), 32'(want.col));
        if (got.row !== want.row)
          report_mismatch("vertex_row", 32'(got.row), 32'(want.row));
        if (got.pos_x !== want.pos_x)
          report_mismatch("pos_x", 32'(got.pos_x), 32'(want.pos_x));
        if (got.pos_z !== want.pos_z)
          report_mismatch("pos_z", 32'(got.pos_z), 32'(want.pos_z));
        if (got.height !== want.height)
          report_mismatch("height_value", 32'(got.height), 32'(want.height));
        if (got.uv_u !== want.uv_u)
          report_mismatch("uv_u", 32'(got.uv_u), 32'(want.uv_u));
        if (got.uv_v !== want.uv_v)
          report_mismatch("uv_v", 32'(got.uv_v), 32'(want.uv_v));
        if (got.nx !== want.nx)
          report_mismatch("normal_x", 32'(got.nx), 32'(want.nx));
        if (got.ny !== want.ny)
          report_mismatch("normal_y", 32'(got.ny), 32'(want.ny));
        if (got.nz !== want.nz)
          report_mismatch("normal_z", 32'(got.nz), 32'(want.nz));
        if (got.last !== want.last)
          report_mismatch("frame_last", 32'(got.last), 32'(want.last));
      end
      idle_cycles = 0;
    end else if (in_hit) begin
      idle_cycles = 0;
    end else if (idle_cycles++ >= IdleLimit) begin
      $display("Timeout: no beat moved for %0d cycles", IdleLimit);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  pixel_row_t pixel_tab [16];

  initial begin
    int unsigned w, h;
    in_if.valid = 1'b0;
    in_if.flush = 1'b0;
    in_if.red_byte = '0;
    in_if.green_byte = '0;
    in_if.blue_byte = '0;
    known_pending = 1'b0;
    pixel_tab[0]  = '{1'b1, 8'h00, 8'h00, 8'h00, 1'b0, 24'h0, 1'b0};
    pixel_tab[1]  = '{1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 24'h0, 1'b0};
    pixel_tab[2]  = '{1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b0, 24'h0, 1'b0};
    pixel_tab[3]  = '{1'b0, 8'h80, 8'h00, 8'h00, 1'b1, 24'h800000, 1'b0};
    pixel_tab[4]  = '{1'b0, 8'h7F, 8'hFF, 8'hFF, 1'b1, 24'h7FFFFF, 1'b0};
    pixel_tab[5]  = '{1'b0, 8'h12, 8'h34, 8'h56, 1'b0, 24'h0, 1'b0};
    pixel_tab[6]  = '{1'b1, 8'h00, 8'h00, 8'h00, 1'b1, 24'h000000, 1'b0};
    pixel_tab[7]  = '{1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b1, 24'hFFFFFF, 1'b1};
    pixel_tab[8]  = '{1'b0, 8'h55, 8'h55, 8'h55, 1'b0, 24'h0, 1'b0};
    pixel_tab[9]  = '{1'b0, 8'h55, 8'h55, 8'h55, 1'b0, 24'h0, 1'b0};
    pixel_tab[10] = '{1'b1, 8'h00, 8'h00, 8'h00, 1'b0, 24'h0, 1'b0};
    pixel_tab[11] = '{1'b0, 8'h55, 8'h55, 8'h55, 1'b1, 24'hD55555, 1'b0};
    pixel_tab[12] = '{1'b0, 8'hAA, 8'hAA, 8'hAA, 1'b0, 24'h0, 1'b0};
    pixel_tab[13] = '{1'b0, 8'h01, 8'h02, 8'h03, 1'b0, 24'h0, 1'b0};
    pixel_tab[14] = '{1'b1, 8'h00, 8'h00, 8'h00, 1'b0, 24'h0, 1'b0};
    pixel_tab[15] = '{1'b1, 8'h00, 8'h00, 8'h00, 1'b1, 24'h2AAAAA, 1'b1};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sizes are clamped, so extreme register values are written while idle first.
    write_size(hvn_pkg::CfgMapHeight, 13'd8191);
    write_size(hvn_pkg::CfgMapWidth, 13'd0);
    write_size(hvn_pkg::CfgMapHeight, 13'd2);
    for (int i = 0; i < 16; i++) begin
      known_row = pixel_tab[i];
      known_pending = pixel_tab[i].known;
      send_beat(pixel_tab[i].flush, pixel_tab[i].r, pixel_tab[i].g, pixel_tab[i].b);
    end
    drain_idle();

    for (int phase = 0; beats_in < 1800; phase++) begin
      idle_en = (phase != 3);
      w = ($urandom_range(9) == 0) ? 2 : $urandom_range(16, 2);
      h = ($urandom_range(9) == 0) ? 2 : $urandom_range(8, 2);
      write_size(hvn_pkg::CfgMapWidth, 13'(w));
      write_size(hvn_pkg::CfgMapHeight, 13'(h));
      repeat ($urandom_range(2, 1)) begin
        send_map(w, h, $urandom_range(2), $urandom_range(3) == 0);
        if (phase == 5) begin
          in_if.valid <= 1'b0;
          while (vertex_q.size() != 0) @(posedge clk);
        end
      end
      drain_idle();
    end

    $display("Sent %0d beats over %0d maps, widths 2 to 16 with stray beats; %0d vertices checked.",
             beats_in, maps_done, vertices_seen);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
